### rtl/sf_pkg.sv
package sf_pkg;

    localparam int MAX_BINS  = 4096;
    localparam int MAG_BITS  = 16;
    localparam int IDX_W     = $clog2(MAX_BINS);
    localparam int CNT_W     = 13;
    localparam int SUM_W     = 2 * MAG_BITS + IDX_W;
    localparam int ROOT_W    = (SUM_W + 1) / 2;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 2;
    localparam int FRAC_BITS = 8;
    localparam int DIV_W     = ROOT_W + FRAC_BITS;
    localparam int STEP_W    = $clog2(DIV_W);
    localparam int FLUX_W    = 24;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 3);

    localparam logic [CNT_W-1:0] BIN_COUNT_RESET = CNT_W'(513);

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } sf_job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQRT,
        ST_DIV,
        ST_DONE
    } sf_state_t;

    function automatic logic [CNT_W-1:0] sf_eff_count(input logic [CNT_W-1:0] raw);
        logic [CNT_W-1:0] c;
        c = raw;
        if (c == '0) begin
            c = CNT_W'(1);
        end
        if (c > CNT_W'(MAX_BINS)) begin
            c = CNT_W'(MAX_BINS);
        end
        return c;
    endfunction

endpackage

### rtl/spectral_flux.sv
// Bins are taken at one per cycle while s_tready is high; a three-stage front reads the stored bin,
// squares the difference and accumulates; the sum is pushed as the square of the last bin is added.
// The flux of a spectrum is formed after its last bin by 22 square-root
// steps and 30 division steps of the shared back-end unit, plus queue and output stages.
// The back end takes one spectrum at a time; a four-entry queue absorbs short spectra.
// After reset all 4096 bin-store entries are cleared with s_tready low; bin_count resets to 513.
module spectral_flux import sf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,   // bin_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // magnitude [15:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata        // flux_value [23:0]
);

    logic [CNT_W-1:0]  bin_count_reg;
    logic              push;
    sf_job_t           push_job;
    logic              pop;
    logic              not_empty;
    sf_job_t           head_job;
    logic [QCNT_W-1:0] q_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_count_reg <= BIN_COUNT_RESET;
        end else if (cfg_wr_en) begin
            bin_count_reg <= cfg_wr_data;
        end
    end

    sf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .bin_count (bin_count_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mag    (s_tdata),
        .q_count   (q_count),
        .push      (push),
        .push_job  (push_job)
    );

    sf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .not_empty (not_empty),
        .head_job  (head_job),
        .count     (q_count)
    );

    sf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (not_empty),
        .job       (head_job),
        .job_pop   (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_flux  (m_tdata)
    );

endmodule

### rtl/sf_front.sv
module sf_front import sf_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [CNT_W-1:0]    bin_count,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [MAG_BITS-1:0] in_mag,
    input  logic [QCNT_W-1:0]   q_count,
    output logic                push,
    output sf_job_t             push_job
);

    logic [MAG_BITS-1:0] mem [MAX_BINS];

    logic                clr_active_reg, clr_active_next;
    logic [IDX_W-1:0]    clr_addr_reg, clr_addr_next;
    logic [IDX_W-1:0]    bin_index_reg, bin_index_next;

    logic                valid_a_reg, last_a_reg;
    logic [MAG_BITS-1:0] mag_a_reg, prev_a_reg;
    logic [CNT_W-1:0]    count_a_reg;

    logic                     valid_b_reg, last_b_reg;
    logic [2*MAG_BITS-1:0]    sq_b_reg;
    logic [CNT_W-1:0]         count_b_reg;

    logic [SUM_W-1:0]    sum_reg, sum_next;

    logic                accept;
    logic [CNT_W-1:0]    count_eff;
    logic                is_last;
    logic [QCNT_W-1:0]   pending;
    logic [MAG_BITS-1:0] diff_a;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_addr;
    logic [MAG_BITS-1:0] mem_wdata;

    assign count_eff = sf_eff_count(bin_count);
    assign is_last   = ({1'b0, bin_index_reg} + CNT_W'(1)) >= count_eff;
    assign pending   = q_count + QCNT_W'(valid_a_reg & last_a_reg)
                     + QCNT_W'(valid_b_reg & last_b_reg);
    assign in_ready  = !clr_active_reg && (pending < QCNT_W'(QDEPTH));
    assign accept    = in_valid && in_ready;

    always_comb begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg) begin
            clr_addr_next = clr_addr_reg + IDX_W'(1);
            if (clr_addr_reg == IDX_W'(MAX_BINS - 1)) begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_comb begin
        bin_index_next = bin_index_reg;
        if (accept) begin
            bin_index_next = is_last ? '0 : bin_index_reg + IDX_W'(1);
        end
    end

    assign mem_we    = clr_active_reg || accept;
    assign mem_addr  = clr_active_reg ? clr_addr_reg : bin_index_reg;
    assign mem_wdata = clr_active_reg ? '0 : in_mag;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (accept) begin
            prev_a_reg <= mem[bin_index_reg];
        end
    end

    assign diff_a = (mag_a_reg >= prev_a_reg) ? mag_a_reg - prev_a_reg
                                              : prev_a_reg - mag_a_reg;

    always_comb begin
        sum_next = sum_reg;
        if (valid_b_reg) begin
            sum_next = last_b_reg ? '0 : sum_reg + SUM_W'(sq_b_reg);
        end
    end

    assign push           = valid_b_reg && last_b_reg;
    assign push_job.sum   = sum_reg + SUM_W'(sq_b_reg);
    assign push_job.count = count_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            bin_index_reg  <= '0;
            valid_a_reg    <= 1'b0;
            valid_b_reg    <= 1'b0;
            sum_reg        <= '0;
        end else begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            bin_index_reg  <= bin_index_next;
            valid_a_reg    <= accept;
            valid_b_reg    <= valid_a_reg;
            sum_reg        <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_a_reg   <= in_mag;
        last_a_reg  <= is_last;
        count_a_reg <= count_eff;
        sq_b_reg    <= diff_a * diff_a;
        last_b_reg  <= last_a_reg;
        count_b_reg <= count_a_reg;
    end

endmodule

### rtl/sf_queue.sv
module sf_queue import sf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  sf_job_t           push_job,
    input  logic              pop,
    output logic              not_empty,
    output sf_job_t           head_job,
    output logic [QCNT_W-1:0] count
);

    sf_job_t            entries [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign not_empty = (count_reg != '0);
    assign head_job  = entries[rd_ptr_reg];
    assign count     = count_reg;

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

### rtl/sf_back.sv
module sf_back import sf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_valid,
    input  sf_job_t           job,
    output logic              job_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [FLUX_W-1:0] out_flux
);

    sf_state_t          state_reg, state_next;
    logic [RAD_W-1:0]   rad_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DIV_W-1:0]   dvd_reg;
    logic [CNT_W-1:0]   drem_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               out_valid_reg;
    logic [FLUX_W-1:0]  out_flux_reg;

    logic               out_free;
    logic               load_out;
    logic               last_step;

    logic [REM_W:0]     rem_sh;
    logic [REM_W:0]     trial;
    logic               sq_take;
    logic [REM_W-1:0]   rem_step;
    logic [ROOT_W-1:0]  root_step;

    logic [CNT_W:0]     drem_sh;
    logic               dv_take;
    logic [CNT_W-1:0]   drem_step;
    logic [DIV_W-1:0]   dvd_step;
    logic [FLUX_W-1:0]  flux_sat;

    assign out_free  = !out_valid_reg || out_ready;
    assign last_step = (step_reg == '0);

    assign rem_sh    = {rem_reg[REM_W-2:0], rad_reg[RAD_W-1 -: 2]};
    assign trial     = (REM_W + 1)'({root_reg, 2'b01});
    assign sq_take   = rem_sh >= trial;
    assign rem_step  = sq_take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
    assign root_step = {root_reg[ROOT_W-2:0], sq_take};

    assign drem_sh   = {drem_reg, dvd_reg[DIV_W-1]};
    assign dv_take   = drem_sh >= {1'b0, cnt_reg};
    assign drem_step = dv_take ? CNT_W'(drem_sh - {1'b0, cnt_reg}) : CNT_W'(drem_sh);
    assign dvd_step  = {dvd_reg[DIV_W-2:0], dv_take};

    assign flux_sat  = (dvd_reg > DIV_W'({FLUX_W{1'b1}})) ? {FLUX_W{1'b1}}
                                                         : FLUX_W'(dvd_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (last_step) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (last_step) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        job_pop  = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                job_pop = job_valid;
            end
            ST_DONE: begin
                load_out = out_free;
            end
            default: begin
                job_pop  = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                rad_reg  <= RAD_W'(job.sum);
                cnt_reg  <= job.count;
                rem_reg  <= '0;
                root_reg <= '0;
                step_reg <= STEP_W'(ROOT_W - 1);
            end
            ST_SQRT: begin
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                rem_reg  <= rem_step;
                root_reg <= root_step;
                if (last_step) begin
                    dvd_reg  <= {root_step, FRAC_BITS'(0)};
                    drem_reg <= '0;
                    step_reg <= STEP_W'(DIV_W - 1);
                end else begin
                    step_reg <= step_reg - STEP_W'(1);
                end
            end
            ST_DIV: begin
                dvd_reg  <= dvd_step;
                drem_reg <= drem_step;
                step_reg <= step_reg - STEP_W'(1);
            end
            default: begin
                step_reg <= step_reg;
            end
        endcase
        if (load_out) begin
            out_flux_reg <= flux_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_flux  = out_flux_reg;

endmodule
